### hdl/qre_pkg.sv
`timescale 1ns / 1ps

package qre_pkg;

  localparam int QW = 16;
  localparam int RW = 32;
  localparam int AW = 35;
  localparam int MW = 34;
  localparam int PW = 2 * MW;
  localparam int NW = 64;
  localparam int DW = 40;
  localparam int HW = 20;
  localparam int RATE_SHIFT = 18;
  localparam int XW = 36;
  localparam int ZW = 35;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [HW-1:0] STEP_RESET = HW'(1000);
  localparam logic [MW-1:0] US_X2 = MW'(2000000);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(64'd1686629713);
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  localparam logic [29:0] ATAN_LUT [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // {negate, index of previous component}, row = result component, col = current component
  localparam logic [2:0] QMUL_MAP [16] = '{
    3'b000, 3'b001, 3'b010, 3'b011,
    3'b101, 3'b000, 3'b111, 3'b010,
    3'b110, 3'b011, 3'b000, 3'b101,
    3'b111, 3'b110, 3'b001, 3'b000
  };

endpackage

### hdl/qre_mul.sv
`timescale 1ns / 1ps

module qre_mul (
  input  logic                             clk_i,
  input  logic signed [qre_pkg::MW-1:0]    a_i,
  input  logic signed [qre_pkg::MW-1:0]    b_i,
  output logic signed [qre_pkg::PW-1:0]    p_o
);
  import qre_pkg::*;

  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### hdl/qre_sqrt.sv
`timescale 1ns / 1ps

module qre_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [qre_pkg::NW-1:0]    rad_i,
  output logic                      done_o,
  output logic [31:0]               root_o
);
  import qre_pkg::*;

  logic [NW-1:0] s_q, s_d, res_q, res_d, bit_q, bit_d, trial;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    trial  = res_q + bit_q;
    s_d    = s_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      s_d    = rad_i;
      res_d  = '0;
      bit_d  = NW'(1) << (NW - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (s_q >= trial) begin
        s_d   = s_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

### hdl/qre_cordic.sv
`timescale 1ns / 1ps

module qre_cordic #(
  parameter int STEPS = qre_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic [31:0]        y_i,
  output logic               done_o,
  output logic [31:0]        phi_o
);
  import qre_pkg::*;

  localparam int CW = $clog2(STEPS);

  logic signed [XW-1:0] x_q, x_d, y_q, y_d, xs, ys, dx, dy;
  logic signed [ZW-1:0] z_q, z_d, at;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [4:0]           k;
  logic                 busy_q, busy_d, done_q, done_d;

  always_comb begin
    xs     = XW'(x_i);
    ys     = signed'({{(XW-32){1'b0}}, y_i});
    k      = 5'(cnt_q);
    dx     = y_q >>> k;
    dy     = x_q >>> k;
    at     = signed'({{(ZW-30){1'b0}}, ATAN_LUT[k]});
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      if (x_i < 0) begin
        x_d = ys;
        y_d = -xs;
        z_d = HALF_PI;
      end else begin
        x_d = xs;
        y_d = ys;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign phi_o  = (z_q < 0) ? 32'd0 : z_q[31:0];

endmodule

### hdl/qre_div.sv
`timescale 1ns / 1ps

module qre_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [qre_pkg::NW-1:0]    num_i,
  input  logic [qre_pkg::DW-1:0]    den_i,
  output logic                      done_o,
  output logic [qre_pkg::NW-1:0]    quo_o
);
  import qre_pkg::*;

  localparam int CW = $clog2(NW);

  logic [NW-1:0] nq_q, nq_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_q, rem_d, sh;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d, qbit;

  always_comb begin
    sh     = {rem_q[DW-1:0], nq_q[NW-1]};
    qbit   = (sh >= {1'b0, den_q});
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      nq_d   = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? (sh - {1'b0, den_q}) : sh;
      nq_d  = {nq_q[NW-2:0], qbit};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

### hdl/quaternion_rate_estimator.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   quat_w_i quat_x_i quat_y_i quat_z_i
// out       out_valid_o / out_stall_i omega_x_o omega_y_o omega_z_o saturated_o
// cfg       cfg_we_i                  cfg_wdata_i (step_time_us)
//
// Per item, six multiply-then-divide passes through the bit-serial 64-bit divider dominate, after
// the transfer in, the quaternion product, the squares, the square root and the CORDIC angle search;
// the output load ends the item. Zero-vector items skip CORDIC and division. The first item is only
// stored as the previous sample and gives no result.
// Reset clears state and the previous-sample flag and sets the step time to 1000.
// A finished result sits in the output register; the next transfer in is taken meanwhile.

module quaternion_rate_estimator #(
  parameter int CORDIC_STEPS = qre_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qre_pkg::HW-1:0]            cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [qre_pkg::QW-1:0]     quat_w_i,
  input  logic signed [qre_pkg::QW-1:0]     quat_x_i,
  input  logic signed [qre_pkg::QW-1:0]     quat_y_i,
  input  logic signed [qre_pkg::QW-1:0]     quat_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                omega_x_o,
  output logic signed [31:0]                omega_y_o,
  output logic signed [31:0]                omega_z_o,
  output logic                              saturated_o
);
  import qre_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_QMUL = 8'b0000_0010,
    S_SQR  = 8'b0000_0100,
    S_SQRT = 8'b0000_1000,
    S_CORD = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic signed [QW-1:0] cur_q [4];
  logic signed [QW-1:0] cur_d [4];
  logic signed [QW-1:0] prev_q [4];
  logic signed [QW-1:0] prev_d [4];
  logic signed [RW-1:0] rv_q [4];
  logic signed [RW-1:0] rv_d [4];
  logic [31:0]          om_q [3];
  logic [31:0]          om_d [3];
  logic                 have_q, have_d;
  logic [HW-1:0]        step_q;
  logic signed [AW-1:0] acc_q, acc_d, term, sum, quart;
  logic [NW-1:0]        ss_q, ss_d;
  logic [31:0]          vmag_q, vmag_d, phi_q, phi_d;
  logic [32:0]          a_q, a_d;
  logic [3:0]           idx_q, idx_d;
  logic [1:0]           comp_q, comp_d, vsel;
  logic                 ph_q, ph_d, second_q, second_d, sat_q, sat_d;
  logic [31:0]          ox_q, oy_q, oz_q;
  logic                 osat_q, out_valid_q, out_valid_d, out_load, out_free;
  logic [2:0]           map;
  logic signed [RW-1:0] vsig;
  logic [31:0]          vabs, clip;
  logic                 clip_sat;
  logic [HW-1:0]        hval;

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic                 sq_start, sq_done, cd_start, cd_done, dv_start, dv_done;
  logic [31:0]          root, phi;
  logic [NW-1:0]        dv_num, quo;
  logic [DW-1:0]        dv_den;

  qre_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(prod));

  qre_sqrt u_sqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start), .rad_i(ss_q),
    .done_o(sq_done), .root_o(root)
  );

  qre_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cd_start), .x_i(rv_q[0]), .y_i(vmag_q),
    .done_o(cd_done), .phi_o(phi)
  );

  qre_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(quo)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hval       = (step_q == '0) ? HW'(1) : step_q;

  always_comb begin
    map   = QMUL_MAP[idx_q];
    vsel  = comp_q + 2'd1;
    vsig  = rv_q[vsel];
    vabs  = (vsig < 0) ? 32'(-vsig) : 32'(vsig);
    term  = map[2] ? -AW'(prod) : AW'(prod);
    sum   = acc_q + term;
    quart = (sum < 0) ? -((-sum) >>> 2) : (sum >>> 2);
    if (vsig < 0) begin
      clip_sat = (quo > NW'(NEG_MAX));
      clip     = clip_sat ? NEG_MAX : (32'd0 - quo[31:0]);
    end else begin
      clip_sat = (quo > NW'(POS_MAX));
      clip     = clip_sat ? POS_MAX : quo[31:0];
    end

    ma = '0;
    mb = '0;
    unique case (state_q)
      S_QMUL: begin
        ma = MW'(cur_q[idx_q[1:0]]);
        mb = MW'(prev_q[map[1:0]]);
      end
      S_SQR: begin
        ma = MW'(vsig);
        mb = MW'(vsig);
      end
      S_MUL: begin
        if (second_q) begin
          ma = signed'({1'b0, a_q});
          mb = signed'(US_X2);
        end else begin
          ma = signed'({2'b00, phi_q});
          mb = signed'({2'b00, vabs});
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase

    sq_start = (state_q == S_SQRT) && !ph_q;
    cd_start = (state_q == S_CORD) && !ph_q;
    dv_start = (state_q == S_MUL) && ph_q;
    dv_num   = NW'(prod);
    dv_den   = second_q ? DW'({hval, {RATE_SHIFT{1'b0}}}) : DW'(vmag_q);
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    rv_d     = rv_q;
    om_d     = om_q;
    have_d   = have_q;
    acc_d    = acc_q;
    ss_d     = ss_q;
    vmag_d   = vmag_q;
    phi_d    = phi_q;
    a_d      = a_q;
    idx_d    = idx_q;
    comp_d   = comp_q;
    ph_d     = ph_q;
    second_d = second_q;
    sat_d    = sat_q;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (have_q) begin
            cur_d   = '{quat_w_i, quat_x_i, quat_y_i, quat_z_i};
            idx_d   = '0;
            ph_d    = 1'b0;
            acc_d   = '0;
            state_d = S_QMUL;
          end else begin
            prev_d = '{quat_w_i, quat_x_i, quat_y_i, quat_z_i};
            have_d = 1'b1;
          end
        end
      end
      S_QMUL: begin
        ph_d = !ph_q;
        if (ph_q) begin
          acc_d = sum;
          if (idx_q[1:0] == 2'd3) begin
            rv_d[idx_q[3:2]] = RW'(quart);
            acc_d = '0;
          end
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd15) begin
            comp_d  = '0;
            ss_d    = '0;
            state_d = S_SQR;
          end
        end
      end
      S_SQR: begin
        ph_d = !ph_q;
        if (ph_q) begin
          ss_d   = ss_q + NW'(prod);
          comp_d = comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            comp_d  = '0;
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        ph_d = 1'b1;
        if (ph_q && sq_done) begin
          vmag_d = root;
          ph_d   = 1'b0;
          if (root == '0) begin
            om_d    = '{32'd0, 32'd0, 32'd0};
            sat_d   = 1'b0;
            state_d = S_OUT;
          end else begin
            state_d = S_CORD;
          end
        end
      end
      S_CORD: begin
        ph_d = 1'b1;
        if (ph_q && cd_done) begin
          phi_d    = phi;
          ph_d     = 1'b0;
          comp_d   = '0;
          second_d = 1'b0;
          sat_d    = 1'b0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        ph_d = !ph_q;
        if (ph_q) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          if (!second_q) begin
            a_d      = 33'(quo);
            second_d = 1'b1;
            state_d  = S_MUL;
          end else begin
            om_d[comp_q] = clip;
            sat_d        = sat_q | clip_sat;
            second_d     = 1'b0;
            comp_d       = comp_q + 2'd1;
            state_d      = (comp_q == 2'd2) ? S_OUT : S_MUL;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          prev_d   = cur_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_q      <= 1'b0;
      prev_q      <= '{default: '0};
      step_q      <= STEP_RESET;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      comp_q      <= '0;
      ph_q        <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_q      <= have_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      comp_q      <= comp_d;
      ph_q        <= ph_d;
      second_q    <= second_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rv_q   <= rv_d;
    om_q   <= om_d;
    acc_q  <= acc_d;
    ss_q   <= ss_d;
    vmag_q <= vmag_d;
    phi_q  <= phi_d;
    a_q    <= a_d;
    sat_q  <= sat_d;
    if (out_load) begin
      ox_q   <= om_d[0];
      oy_q   <= om_d[1];
      oz_q   <= om_d[2];
      osat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign omega_x_o   = signed'(ox_q);
  assign omega_y_o   = signed'(oy_q);
  assign omega_z_o   = signed'(oz_q);
  assign saturated_o = osat_q;

  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result appeared outside the output state");

  a_qmul_has_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QMUL) |-> have_q)
    else $error("quaternion product without a previous sample");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_vmag_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (vmag_q != '0))
    else $error("angle search started on a zero vector");

endmodule
